// ===== design/lkv_pkg.sv =====
package lkv_pkg;

   localparam int ENTRIES    = 32;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 32;
   localparam int CFG_BITS   = 6;

   localparam int SLOT_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int AGE_BITS   = SLOT_BITS;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);
   localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

   localparam logic [CFG_BITS-1:0] CAP_RESET = CFG_BITS'(32);

   typedef enum logic {
      KIND_GET = 1'b0,
      KIND_PUT = 1'b1
   } kind_type;

   typedef struct packed {
      logic                  kind;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] write_value;
   } req_payload_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_TOUCH,
      UPD_INSERT
   } upd_kind_type;

   typedef struct packed {
      logic         load;
      logic         lookup;
      upd_kind_type update;
      logic         respond;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic is_put;
   } status_type;

endpackage

// ===== design/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
//
// Request channel: drive req_payload (kind, key, write_value) and raise start;
// the request is taken on a rising edge where start is high and busy is low.
// busy stays high until the response has been shown.
// Response channel: rsp_valid is high for exactly one cycle with rsp_payload
// (hit, read_value, evicted, evicted_key). The receiver cannot stall it; a
// response not captured in that cycle is gone.
// Sequence: a request passes through key compare over all entries, age-rank
// update plus value RAM access, then the response register; a new request
// is taken only after the previous response has been shown.
// Capacity register: csr_valid/csr_data write capacity_in_use (6 bits);
// csr_ready is always high. Write it only while busy is low.
// Reset (synchronous, active high) empties the cache, clears all age ranks
// and sets the capacity to 32; no clearing pass is needed.
module lru_key_value_cache
   import lkv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_BITS-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lkv_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_write   (csr_valid & csr_ready),
      .csr_data    (csr_data),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/lkv_ram.sv =====
module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [WIDTH-1:0]     wr_data,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lkv_ctrl.sv =====
module lkv_ctrl
   import lkv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      respond_ff, respond_in;

   always_comb begin
      state_in   = state_ff;
      busy_in    = busy_ff;
      respond_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
               busy_in  = 1'b1;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in   = ST_RESPOND;
            respond_in = 1'b1;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         busy_ff    <= 1'b0;
         respond_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         busy_ff    <= busy_in;
         respond_ff <= respond_in;
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.load    = start & ~busy_ff;
      cmd.lookup  = (state_ff == ST_LOOKUP);
      cmd.respond = respond_ff;
      cmd.update  = UPD_NONE;
      if (state_ff == ST_UPDATE) begin
         if (status.hit) begin
            cmd.update = UPD_TOUCH;
         end else if (status.is_put) begin
            cmd.update = UPD_INSERT;
         end
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = respond_ff;

endmodule

// ===== design/lkv_datapath.sv =====
module lkv_datapath
   import lkv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  req_payload_type req_payload,
   input  logic            csr_write,
   input  logic [CFG_BITS-1:0] csr_data,
   output status_type      status,
   output rsp_payload_type rsp_payload
);

   req_payload_type       req_ff;
   logic                  entry_valid_ff [ENTRIES];
   logic [KEY_BITS-1:0]   entry_key_ff   [ENTRIES];
   logic [AGE_BITS-1:0]   entry_age_ff   [ENTRIES];
   logic [COUNT_BITS-1:0] fill_count_ff;
   logic [CFG_BITS-1:0]   capacity_ff;

   logic                  hit_ff, hit_in;
   logic                  evict_ff, evict_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [KEY_BITS-1:0]   evicted_key_ff, evicted_key_in;

   logic                  hit_found;
   logic [SLOT_BITS-1:0]  hit_slot, free_slot, victim_slot;
   logic [CMP_BITS-1:0]   cap_ext, fill_ext, eff_cap;
   logic                  full;
   logic [AGE_BITS-1:0]   oldest_age, slot_age;
   logic                  is_put;

   logic                  ram_wr, ram_rd;
   logic [VALUE_BITS-1:0] ram_rd_data;

   assign is_put = (req_ff.kind == KIND_PUT);

   // Effective capacity: zero acts as one, anything above the store size clamps.
   always_comb begin
      cap_ext  = CMP_BITS'(capacity_ff);
      fill_ext = CMP_BITS'(fill_count_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_BITS'(1);
      end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
         eff_cap = CMP_BITS'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full       = (fill_ext >= eff_cap);
   // Ranks of valid entries are distinct, so the oldest one has rank fill - 1.
   assign oldest_age = AGE_BITS'(fill_count_ff - COUNT_BITS'(1));

   // Parallel compare; lowest index wins in each search.
   always_comb begin
      hit_found   = 1'b0;
      hit_slot    = '0;
      free_slot   = '0;
      victim_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (entry_valid_ff[i] && entry_key_ff[i] == req_ff.key) begin
            hit_found = 1'b1;
            hit_slot  = SLOT_BITS'(i);
         end
         if (!entry_valid_ff[i]) begin
            free_slot = SLOT_BITS'(i);
         end
         if (entry_valid_ff[i] && entry_age_ff[i] == oldest_age) begin
            victim_slot = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      hit_in         = hit_ff;
      evict_in       = evict_ff;
      slot_in        = slot_ff;
      evicted_key_in = evicted_key_ff;
      if (cmd.lookup) begin
         hit_in         = hit_found;
         evict_in       = ~hit_found & is_put & full;
         slot_in        = hit_found ? hit_slot : (full ? victim_slot : free_slot);
         evicted_key_in = (~hit_found & is_put & full) ? entry_key_ff[victim_slot] : '0;
      end
   end

   assign slot_age = entry_age_ff[slot_ff];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      slot_ff        <= slot_in;
      evicted_key_ff <= evicted_key_in;
      if (cmd.update == UPD_INSERT) begin
         entry_key_ff[slot_ff] <= req_ff.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            entry_valid_ff[i] <= 1'b0;
            entry_age_ff[i]   <= '0;
         end
         fill_count_ff <= '0;
         capacity_ff   <= CAP_RESET;
         hit_ff        <= 1'b0;
         evict_ff      <= 1'b0;
      end else begin
         hit_ff   <= hit_in;
         evict_ff <= evict_in;
         if (csr_write) begin
            capacity_ff <= csr_data;
         end
         case (cmd.update)
            UPD_TOUCH: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (SLOT_BITS'(i) == slot_ff) begin
                     entry_age_ff[i] <= '0;
                  end else if (entry_valid_ff[i] && entry_age_ff[i] < slot_age) begin
                     entry_age_ff[i] <= entry_age_ff[i] + AGE_BITS'(1);
                  end
               end
            end
            UPD_INSERT: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (SLOT_BITS'(i) == slot_ff) begin
                     entry_valid_ff[i] <= 1'b1;
                     entry_age_ff[i]   <= '0;
                  end else if (entry_valid_ff[i]) begin
                     entry_age_ff[i] <= entry_age_ff[i] + AGE_BITS'(1);
                  end
               end
               if (!evict_ff) begin
                  fill_count_ff <= fill_count_ff + COUNT_BITS'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign ram_wr = (cmd.update != UPD_NONE) & is_put;
   assign ram_rd = (cmd.update == UPD_TOUCH) & ~is_put;

   lkv_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .rd_en   (ram_rd),
      .addr    (slot_ff),
      .wr_data (req_ff.write_value),
      .rd_data (ram_rd_data)
   );

   assign status.hit    = hit_ff;
   assign status.is_put = is_put;

   always_comb begin
      rsp_payload             = '0;
      rsp_payload.hit         = hit_ff;
      rsp_payload.read_value  = (hit_ff & ~is_put) ? ram_rd_data : '0;
      rsp_payload.evicted     = evict_ff;
      rsp_payload.evicted_key = evicted_key_ff;
   end

endmodule

// ===== design/lkv_checker.sv =====
module lkv_checker
   import lkv_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input req_payload_type     req_payload,
   input logic                rsp_valid,
   input rsp_payload_type     rsp_payload,
   input logic                csr_valid,
   input logic                csr_ready,
   input logic [CFG_BITS-1:0] csr_data
);

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response missing three cycles after request");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.evicted) |-> !rsp_payload.hit)
      else $error("eviction reported on a hit");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.hit) |-> (rsp_payload.read_value == '0))
      else $error("nonzero read value on a miss");

endmodule

bind lru_key_value_cache lkv_checker u_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import lkv_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PRINT_LIMIT    = 40;
   localparam int POOL_DEPTH     = 64;
   localparam int POOL_BITS      = $clog2(POOL_DEPTH);

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_payload_type     req_payload;
   logic                rsp_valid;
   rsp_payload_type     rsp_payload;
   logic                csr_valid;
   logic                csr_ready;
   logic [CFG_BITS-1:0] csr_data;

   // shadow copy of the cache contents
   logic                  line_used  [ENTRIES];
   logic [KEY_BITS-1:0]   line_key   [ENTRIES];
   logic [VALUE_BITS-1:0] line_value [ENTRIES];
   int                    line_rank  [ENTRIES];
   int                    lines_filled;
   logic [CFG_BITS-1:0]   capacity_setting;

   rsp_payload_type       pending_rsp [$];
   int                    mismatch_count;
   int                    sender_idle_pct;
   int                    idle_cycles;
   logic [KEY_BITS-1:0]   key_pool [POOL_DEPTH];

   lru_key_value_cache dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic rsp_payload_type predict_access(input req_payload_type rq);
      rsp_payload_type rs;
      int found;
      int slot;
      int oldest;
      int limit;
      rs     = '0;
      found  = -1;
      slot   = -1;
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && line_used[i] && line_key[i] == rq.key)
            found = i;
      if (found >= 0) begin
         rs.hit = 1'b1;
         if (rq.kind == KIND_PUT)
            line_value[found] = rq.write_value;
         else
            rs.read_value = line_value[found];
         // only entries more recent than the touched one move down a rank
         for (int i = 0; i < ENTRIES; i++)
            if (line_used[i] && i != found && line_rank[i] < line_rank[found])
               line_rank[i]++;
         line_rank[found] = 0;
      end else if (rq.kind == KIND_PUT) begin
         limit = int'(capacity_setting);
         if (limit < 1)
            limit = 1;
         if (limit > ENTRIES)
            limit = ENTRIES;
         if (lines_filled >= limit) begin
            // victim: highest rank, lowest index on a tie
            for (int i = 0; i < ENTRIES; i++)
               if (line_used[i] && (slot < 0 || line_rank[i] > oldest)) begin
                  slot   = i;
                  oldest = line_rank[i];
               end
            if (slot >= 0) begin
               rs.evicted     = 1'b1;
               rs.evicted_key = line_key[slot];
               line_used[slot] = 1'b0;
            end
         end else begin
            for (int i = 0; i < ENTRIES; i++)
               if (slot < 0 && !line_used[i])
                  slot = i;
            if (slot >= 0)
               lines_filled++;
         end
         if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
               if (line_used[i])
                  line_rank[i]++;
            line_used[slot]  = 1'b1;
            line_key[slot]   = rq.key;
            line_value[slot] = rq.write_value;
            line_rank[slot]  = 0;
         end
      end
      return rs;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input kind_type op, input logic [KEY_BITS-1:0] k,
                               input logic [VALUE_BITS-1:0] v);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_payload.kind        = op;
      req_payload.key         = k;
      req_payload.write_value = v;
      start = 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_rsp.push_back(predict_access(req_payload));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_for_drain();
      while (pending_rsp.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CFG_BITS-1:0] cap);
      wait_for_drain();
      csr_data  = cap;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      capacity_setting = cap;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_empty_lookups();
      send_request(KIND_GET, '0, '0);
      send_request(KIND_GET, '1, '1);
   endtask

   task automatic test_insert_and_update();
      send_request(KIND_PUT, '0, '0);
      send_request(KIND_PUT, '1, '1);
      send_request(KIND_GET, '0, 32'h1234_5678);
      send_request(KIND_GET, '1, '0);
      send_request(KIND_PUT, '0, 32'hA5A5_5A5A);
      send_request(KIND_GET, '0, '0);
   endtask

   task automatic test_eviction_order();
      write_capacity(CFG_BITS'(2));
      send_request(KIND_PUT, 16'h1111, 32'h0000_1111);
      send_request(KIND_PUT, 16'h2222, 32'h0000_2222);
      send_request(KIND_GET, 16'h1111, '1);
      send_request(KIND_PUT, 16'h3333, 32'h0000_3333);
      send_request(KIND_GET, 16'h2222, '0);
      send_request(KIND_GET, 16'h3333, '0);
   endtask

   // lowering the capacity below occupancy drops nothing until the next put miss
   task automatic test_capacity_lowered();
      write_capacity(CFG_BITS'(32));
      send_request(KIND_PUT, 16'h0101, 32'h0101_0101);
      send_request(KIND_PUT, 16'h0202, 32'h0202_0202);
      send_request(KIND_PUT, 16'h0404, 32'h0404_0404);
      write_capacity(CFG_BITS'(3));
      send_request(KIND_GET, 16'h0101, '0);
      send_request(KIND_PUT, 16'h0505, 32'h0505_0505);
      send_request(KIND_GET, 16'h1111, '0);
   endtask

   // zero behaves as one, anything above the entry count as full size
   task automatic test_capacity_out_of_range();
      write_capacity('0);
      send_request(KIND_PUT, 16'h7777, 32'h7777_7777);
      send_request(KIND_PUT, 16'h8888, 32'h8888_8888);
      write_capacity('1);
      send_request(KIND_PUT, 16'h9999, 32'h9999_9999);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int pool_size);
      logic [KEY_BITS-1:0] k;
      sender_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(19) == 0)
            key_pool[POOL_BITS'($urandom_range(pool_size - 1))] = KEY_BITS'($urandom);
         if ($urandom_range(99) < 85)
            k = key_pool[POOL_BITS'($urandom_range(pool_size - 1))];
         else
            k = KEY_BITS'($urandom);
         // hold off mid-phase until the pipeline is empty
         if (n == count / 2)
            wait_for_drain();
         send_request(kind_type'($urandom_range(1)), k, VALUE_BITS'($urandom));
      end
      sender_idle_pct = 0;
   endtask

   always @(posedge clock) begin : check_responses
      rsp_payload_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with no request pending",
                            64'(rsp_payload.read_value), '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.hit !== want.hit)
               report_mismatch("hit", 64'(rsp_payload.hit), 64'(want.hit));
            if (rsp_payload.read_value !== want.read_value)
               report_mismatch("read_value", 64'(rsp_payload.read_value),
                               64'(want.read_value));
            if (rsp_payload.evicted !== want.evicted)
               report_mismatch("evicted", 64'(rsp_payload.evicted), 64'(want.evicted));
            if (rsp_payload.evicted_key !== want.evicted_key)
               report_mismatch("evicted_key", 64'(rsp_payload.evicted_key),
                               64'(want.evicted_key));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      idle_cycles     = 0;
      mismatch_count  = 0;
      sender_idle_pct = 0;
      lines_filled     = 0;
      capacity_setting = CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
         line_used[i] = 1'b0;
         line_rank[i] = 0;
      end
      for (int i = 0; i < POOL_DEPTH; i++)
         key_pool[i] = KEY_BITS'($urandom);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_lookups();
      test_insert_and_update();
      test_eviction_order();
      test_capacity_lowered();
      test_capacity_out_of_range();

      write_capacity(CFG_BITS'(32));
      test_random_traffic(400, 0, 48);
      write_capacity('1);
      test_random_traffic(300, 86, 40);
      write_capacity(CFG_BITS'(5));
      test_random_traffic(300, 24, 10);
      write_capacity(CFG_BITS'(1));
      test_random_traffic(150, 0, 3);
      write_capacity('0);
      test_random_traffic(100, 24, 3);
      write_capacity(CFG_BITS'($urandom_range(31, 2)));
      test_random_traffic(250, 86, 24);

      wait_for_drain();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
